// File: hw/rtl/glcm_pkg.sv
// Shared types and constants for the gene list crossover merge block.
package glcm_pkg;

	localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
	localparam logic [1:0] KIND_MERGE       = 2'd2;

	localparam int INNOV_W  = 16;
	localparam int WEIGHT_W = 32;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		CMD_LOAD_FIRST,
		CMD_LOAD_SECOND,
		CMD_MERGE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  swap;
		logic                  coin;
		logic [INNOV_W-1:0]    innovation;
		logic                  enabled;
		logic [WEIGHT_W-1:0]   weight;
	} cmd_hdr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_EMPTY
	} back_state_t;

endpackage

// File: hw/rtl/glcm_front.sv
// Front end: takes input beats, drops unused kinds and packs commands for the queue.
module glcm_front
	import glcm_pkg::*;
#(
	parameter int NODE_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             kind,
	input  logic                   second_fitter,
	input  logic [NODE_BITS-1:0]   source_node,
	input  logic [NODE_BITS-1:0]   target_node,
	input  logic [WEIGHT_W-1:0]    weight_bits,
	input  logic                   gene_enabled,
	input  logic [INNOV_W-1:0]     innovation,
	input  logic                   pick_fitter,
	output logic                   push,
	input  logic                   queue_full,
	output cmd_hdr_t               push_hdr,
	output logic [2*NODE_BITS-1:0] push_nodes
);

	logic                   valid_s1;
	cmd_hdr_t               hdr_s1;
	logic [2*NODE_BITS-1:0] nodes_s1;
	logic                   accept;
	logic                   keep;
	cmd_kind_t              dec_kind;

	always_comb begin
		keep     = 1'b1;
		dec_kind = CMD_LOAD_FIRST;
		case (kind)
			KIND_LOAD_FIRST:  dec_kind = CMD_LOAD_FIRST;
			KIND_LOAD_SECOND: dec_kind = CMD_LOAD_SECOND;
			KIND_MERGE:       dec_kind = CMD_MERGE;
			default:          keep = 1'b0;
		endcase
	end

	assign in_stall = valid_s1 && queue_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s1.kind       <= dec_kind;
			hdr_s1.swap       <= second_fitter;
			hdr_s1.coin       <= pick_fitter;
			hdr_s1.innovation <= innovation;
			hdr_s1.enabled    <= gene_enabled;
			hdr_s1.weight     <= weight_bits;
			nodes_s1          <= {target_node, source_node};
		end
	end

	assign push_hdr   = hdr_s1;
	assign push_nodes = nodes_s1;

endmodule

// File: hw/rtl/glcm_cmd_queue.sv
// Short command queue between the front end and the merge engine.
module glcm_cmd_queue
	import glcm_pkg::*;
#(
	parameter int WIDTH = 100
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full      = fill_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = fill_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/glcm_back.sv
// Merge engine: holds both gene lists and walks them to produce the child genes.
module glcm_back
	import glcm_pkg::*;
#(
	parameter int MAX_GENES = 64,
	parameter int NODE_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_pop,
	input  cmd_hdr_t               cmd_hdr,
	input  logic [2*NODE_BITS-1:0] cmd_nodes,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [NODE_BITS-1:0]   child_source,
	output logic [NODE_BITS-1:0]   child_target,
	output logic [WEIGHT_W-1:0]    child_weight,
	output logic                   child_enabled,
	output logic [INNOV_W-1:0]     child_innovation,
	output logic                   empty_child,
	output logic                   last
);

	localparam int CNT_W   = $clog2(MAX_GENES + 1);
	localparam int IDX_W   = $clog2(MAX_GENES);
	localparam int ENT_W   = 1 + INNOV_W + 1 + WEIGHT_W + 2 * NODE_BITS;
	localparam int WT_LO   = 2 * NODE_BITS;
	localparam int EN_POS  = WT_LO + WEIGHT_W;
	localparam int KEY_LO  = EN_POS + 1;
	localparam int COIN_POS = ENT_W - 1;

	// Entry layout: coin, innovation, enabled, weight, target, source.
	logic [ENT_W-1:0] first_mem [MAX_GENES];
	logic [ENT_W-1:0] second_mem [MAX_GENES];
	logic [ENT_W-1:0] first_rd_q;
	logic [ENT_W-1:0] second_rd_q;
	logic [ENT_W-1:0] entry_wr;

	back_state_t state_q;
	back_state_t state_d;
	logic        swap_q;
	logic [CNT_W-1:0] first_cnt_q;
	logic [CNT_W-1:0] second_cnt_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] i_next;
	logic [CNT_W-1:0] fit_cnt;
	logic [CNT_W-1:0] oth_cnt;
	logic [CNT_W-1:0] start_fit_cnt;
	logic [IDX_W-1:0] first_addr;
	logic [IDX_W-1:0] second_addr;

	logic [ENT_W-1:0]   fit_d;
	logic [ENT_W-1:0]   oth_d;
	logic [ENT_W-1:0]   pick_d;
	logic [INNOV_W-1:0] fit_key;
	logic [INNOV_W-1:0] oth_key;
	logic               j_live;
	logic               oth_less;
	logic               match;
	logic               last_gene;
	logic               out_free;
	logic               is_merge;
	logic               wr_first;
	logic               wr_second;

	logic emit_gene;
	logic emit_empty;
	logic step_j;
	logic clear_counts;
	logic start;

	assign entry_wr = {cmd_hdr.coin, cmd_hdr.innovation, cmd_hdr.enabled,
		cmd_hdr.weight, cmd_nodes};

	assign fit_cnt       = swap_q ? second_cnt_q : first_cnt_q;
	assign oth_cnt       = swap_q ? first_cnt_q : second_cnt_q;
	assign start_fit_cnt = cmd_hdr.swap ? second_cnt_q : first_cnt_q;
	assign first_addr    = swap_q ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];
	assign second_addr   = swap_q ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];

	assign fit_d     = swap_q ? second_rd_q : first_rd_q;
	assign oth_d     = swap_q ? first_rd_q : second_rd_q;
	assign fit_key   = fit_d[KEY_LO +: INNOV_W];
	assign oth_key   = oth_d[KEY_LO +: INNOV_W];
	assign j_live    = j_q < oth_cnt;
	assign oth_less  = j_live && (oth_key < fit_key);
	assign match     = j_live && (oth_key == fit_key);
	assign i_next    = i_q + CNT_W'(1);
	assign last_gene = i_next == fit_cnt;
	assign out_free  = !out_valid || !out_stall;
	assign is_merge  = cmd_hdr.kind == CMD_MERGE;

	// On a shared innovation the fitter gene's coin picks which gene is kept.
	assign pick_d = (match && !fit_d[COIN_POS]) ? oth_d : fit_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && is_merge) begin
					state_d = (start_fit_cnt == '0) ? ST_EMPTY : ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (oth_less) begin
					state_d = ST_READ;
				end else if (out_free) begin
					state_d = last_gene ? ST_IDLE : ST_READ;
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop      = 1'b0;
		start        = 1'b0;
		wr_first     = 1'b0;
		wr_second    = 1'b0;
		emit_gene    = 1'b0;
		emit_empty   = 1'b0;
		step_j       = 1'b0;
		clear_counts = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_pop   = cmd_valid;
				start     = cmd_valid && is_merge;
				wr_first  = cmd_valid && (cmd_hdr.kind == CMD_LOAD_FIRST)
					&& (first_cnt_q < CNT_W'(MAX_GENES));
				wr_second = cmd_valid && (cmd_hdr.kind == CMD_LOAD_SECOND)
					&& (second_cnt_q < CNT_W'(MAX_GENES));
			end
			ST_EVAL: begin
				emit_gene    = !oth_less && out_free;
				step_j       = oth_less || (!oth_less && out_free && match);
				clear_counts = !oth_less && out_free && last_gene;
			end
			ST_EMPTY: begin
				emit_empty   = out_free;
				clear_counts = out_free;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			swap_q       <= 1'b0;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			out_valid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				swap_q <= cmd_hdr.swap;
				i_q    <= '0;
				j_q    <= '0;
			end else begin
				if (emit_gene) begin
					i_q <= i_next;
				end
				if (step_j) begin
					j_q <= j_q + CNT_W'(1);
				end
			end
			if (clear_counts) begin
				first_cnt_q  <= '0;
				second_cnt_q <= '0;
			end else begin
				if (wr_first) begin
					first_cnt_q <= first_cnt_q + CNT_W'(1);
				end
				if (wr_second) begin
					second_cnt_q <= second_cnt_q + CNT_W'(1);
				end
			end
			if (emit_gene || emit_empty) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_first) begin
			first_mem[first_cnt_q[IDX_W-1:0]] <= entry_wr;
		end
		first_rd_q <= first_mem[first_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_second) begin
			second_mem[second_cnt_q[IDX_W-1:0]] <= entry_wr;
		end
		second_rd_q <= second_mem[second_addr];
	end

	always_ff @(posedge clk) begin
		if (emit_gene) begin
			child_source     <= pick_d[NODE_BITS-1:0];
			child_target     <= pick_d[NODE_BITS +: NODE_BITS];
			child_weight     <= pick_d[WT_LO +: WEIGHT_W];
			child_enabled    <= pick_d[EN_POS];
			child_innovation <= pick_d[KEY_LO +: INNOV_W];
			empty_child      <= 1'b0;
			last             <= last_gene;
		end else if (emit_empty) begin
			child_source     <= '0;
			child_target     <= '0;
			child_weight     <= '0;
			child_enabled    <= 1'b0;
			child_innovation <= '0;
			empty_child      <= 1'b1;
			last             <= 1'b1;
		end
	end

endmodule

// File: hw/rtl/gene_list_crossover_merge.sv
// Top level of the gene list crossover merge block.
//
//  channel | handshake           | beat
//  in      | in_valid, in_stall  | load first, load second or start merge
//  out     | out_valid, out_stall| one child gene, or one empty marker
//
// The engine takes a load whenever it is idle, so loads stream at one per cycle
// while no merge is under way. A merge walks both lists with one registered memory
// read per step, each step a read state then an evaluate state; there is one step
// per fitter gene plus one per skipped gene of the other list. A start beat passes
// the front register and the queue before the engine takes it. Reset clears the
// list counts, the command queue and the engine; no sweep of the gene memories is
// needed. Out-stall holds the engine only when it has output ready; the front keeps
// taking beats until the four-entry queue and its own register are full.
module gene_list_crossover_merge
	import glcm_pkg::*;
#(
	parameter int MAX_GENES = 64,
	parameter int NODE_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           kind,
	input  logic                 second_fitter,
	input  logic [NODE_BITS-1:0] source_node,
	input  logic [NODE_BITS-1:0] target_node,
	input  logic [WEIGHT_W-1:0]  weight_bits,
	input  logic                 gene_enabled,
	input  logic [INNOV_W-1:0]   innovation,
	input  logic                 pick_fitter,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [NODE_BITS-1:0] child_source,
	output logic [NODE_BITS-1:0] child_target,
	output logic [WEIGHT_W-1:0]  child_weight,
	output logic                 child_enabled,
	output logic [INNOV_W-1:0]   child_innovation,
	output logic                 empty_child,
	output logic                 last
);

	localparam int Q_W = $bits(cmd_hdr_t) + 2 * NODE_BITS;

	logic                   push;
	logic                   queue_full;
	cmd_hdr_t               push_hdr;
	logic [2*NODE_BITS-1:0] push_nodes;
	logic                   cmd_valid;
	logic                   cmd_pop;
	logic [Q_W-1:0]         cmd_data;
	cmd_hdr_t               cmd_hdr;
	logic [2*NODE_BITS-1:0] cmd_nodes;

	glcm_front #(
		.NODE_BITS(NODE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.second_fitter(second_fitter),
		.source_node  (source_node),
		.target_node  (target_node),
		.weight_bits  (weight_bits),
		.gene_enabled (gene_enabled),
		.innovation   (innovation),
		.pick_fitter  (pick_fitter),
		.push         (push),
		.queue_full   (queue_full),
		.push_hdr     (push_hdr),
		.push_nodes   (push_nodes)
	);

	glcm_cmd_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_hdr, push_nodes}),
		.full     (queue_full),
		.pop      (cmd_pop),
		.not_empty(cmd_valid),
		.pop_data (cmd_data)
	);

	assign cmd_hdr   = cmd_hdr_t'(cmd_data[Q_W-1:2*NODE_BITS]);
	assign cmd_nodes = cmd_data[2*NODE_BITS-1:0];

	glcm_back #(
		.MAX_GENES(MAX_GENES),
		.NODE_BITS(NODE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_pop         (cmd_pop),
		.cmd_hdr         (cmd_hdr),
		.cmd_nodes       (cmd_nodes),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.child_source    (child_source),
		.child_target    (child_target),
		.child_weight    (child_weight),
		.child_enabled   (child_enabled),
		.child_innovation(child_innovation),
		.empty_child     (empty_child),
		.last            (last)
	);

endmodule
